// File: src/eab_pkg.sv
// ----------------------------------------------------------------------------
// eab_pkg
// Shared types, constants and arithmetic helpers for the Euler-angle to
// basis-vector block.
// ----------------------------------------------------------------------------
package eab_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int WORK_FRAC     = 30;
  localparam int CORDIC_STEPS  = 30;
  localparam int XY_W          = 34;
  localparam int Z_W           = 33;
  localparam int TRIG_W        = 32;
  localparam int SUM_W         = 33;
  localparam int OUT_SH        = WORK_FRAC - OUT_FRAC_BITS;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;
  localparam int OUT_DEPTH     = 64;
  localparam int OUT_AW        = 6;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  localparam logic signed [Z_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
    33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
    33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
    33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA,
    33'sh0000517D, 33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
    33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051, 33'sh00000029,
    33'sh00000014, 33'sh0000000A, 33'sh00000005, 33'sh00000003, 33'sh00000001
  };

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
  } result_t;

  typedef struct packed {
    logic [1:0]            quad;
    logic signed [Z_W-1:0] resid;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t yaw;
    lane_t roll;
  } cls_t;

  function automatic lane_t classify(input logic [ANGLE_BITS-1:0] angle);
    logic [31:0] a32;
    logic [31:0] d;
    lane_t       l;
    a32    = 32'(angle) << (32 - ANGLE_BITS);
    l.quad = 2'((a32 + 32'h2000_0000) >> 30);
    d      = a32 - {l.quad, 30'b0};
    l.resid = {d[31], d};
    return l;
  endfunction

  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = (p + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
    return TRIG_W'(p);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W+1:0] t;
    t = (SUM_W+2)'(v) + (SUM_W+2)'((2 ** OUT_SH) / 2);
    t = t >>> OUT_SH;
    if (t > (SUM_W+2)'(2 ** OUT_FRAC_BITS)) begin
      t = (SUM_W+2)'(2 ** OUT_FRAC_BITS);
    end else if (t < -(SUM_W+2)'(2 ** OUT_FRAC_BITS)) begin
      t = -(SUM_W+2)'(2 ** OUT_FRAC_BITS);
    end
    return OUT_W'(t);
  endfunction

endpackage

// File: src/eab_front.sv
// ----------------------------------------------------------------------------
// eab_front
// Input stage: takes a beat, splits each angle into quadrant and residual.
// ----------------------------------------------------------------------------
module eab_front import eab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cls_valid,
  output cls_t  cls,
  input  logic  q_full
);

  logic accept;

  assign full   = cls_valid & q_full;
  assign accept = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else begin
      cls_valid <= accept | (cls_valid & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls.pitch <= classify(item.pitch_angle);
      cls.yaw   <= classify(item.yaw_angle);
      cls.roll  <= classify(item.roll_angle);
    end
  end

endmodule

// File: src/eab_queue.sv
// ----------------------------------------------------------------------------
// eab_queue
// Short queue between front and back.
// ----------------------------------------------------------------------------
module eab_queue import eab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cls_t wdata,
  output logic q_full,
  input  logic rd,
  output logic q_valid,
  output cls_t rdata
);

  cls_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign q_full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rdata   = entries[rptr];
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(do_wr) - (QUEUE_AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wptr] <= wdata;
  end

endmodule

// File: src/eab_cordic.sv
// ----------------------------------------------------------------------------
// eab_cordic
// Pipelined rotation CORDIC: one iteration per stage, quadrant fix at the end.
// ----------------------------------------------------------------------------
module eab_cordic import eab_pkg::*; (
  input  logic  clk,
  input  lane_t lane,
  output trig_t sin_q,
  output trig_t cos_q
);

  logic signed [XY_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  zs [CORDIC_STEPS+1];
  logic [1:0]             qs [CORDIC_STEPS+1];

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = lane.resid;
  assign qs[0] = lane.quad;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!zs[i][Z_W-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - TURN_ATAN[i];
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + TURN_ATAN[i];
      end
      qs[i+1] <= qs[i];
    end
  end

  trig_t xf;
  trig_t yf;
  assign xf = TRIG_W'(xs[CORDIC_STEPS]);
  assign yf = TRIG_W'(ys[CORDIC_STEPS]);

  always_ff @(posedge clk) begin
    unique case (qs[CORDIC_STEPS])
      2'd0: begin cos_q <= xf;  sin_q <= yf;  end
      2'd1: begin cos_q <= -yf; sin_q <= xf;  end
      2'd2: begin cos_q <= -xf; sin_q <= -yf; end
      default: begin cos_q <= yf; sin_q <= -xf; end
    endcase
  end

endmodule

// File: src/eab_back.sv
// ----------------------------------------------------------------------------
// eab_back
// Sine/cosine lanes, product, sum and rounding stages, and the result queue.
// ----------------------------------------------------------------------------
module eab_back import eab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cls_t    q_data,
  output logic    q_rd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int PIPE = CORDIC_STEPS + 5;

  logic [PIPE-1:0] vpipe;
  logic [OUT_AW:0] pending;
  logic            pop_acc;

  assign q_rd    = q_valid & (pending < (OUT_AW+1)'(OUT_DEPTH));
  assign pop_acc = pop & ~empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe   <= '0;
      pending <= '0;
    end else begin
      vpipe   <= {vpipe[PIPE-2:0], q_rd};
      pending <= pending + (OUT_AW+1)'(q_rd) - (OUT_AW+1)'(pop_acc);
    end
  end

  trig_t sp, cp, sy, cy, sr, cr;

  eab_cordic u_pitch (.clk(clk), .lane(q_data.pitch), .sin_q(sp), .cos_q(cp));
  eab_cordic u_yaw   (.clk(clk), .lane(q_data.yaw),   .sin_q(sy), .cos_q(cy));
  eab_cordic u_roll  (.clk(clk), .lane(q_data.roll),  .sin_q(sr), .cos_q(cr));

  // first products
  trig_t spcy, spsy, cpcy, cpsy, crsy, crcy, srcp, crcp, srsy, srcy, sp1, sr1, cr1;
  always_ff @(posedge clk) begin
    spcy <= qmul(sp, cy);
    spsy <= qmul(sp, sy);
    cpcy <= qmul(cp, cy);
    cpsy <= qmul(cp, sy);
    crsy <= qmul(cr, sy);
    crcy <= qmul(cr, cy);
    srcp <= qmul(sr, cp);
    crcp <= qmul(cr, cp);
    srsy <= qmul(sr, sy);
    srcy <= qmul(sr, cy);
    sp1  <= sp;
    sr1  <= sr;
    cr1  <= cr;
  end

  // three-way products
  trig_t a2, b2, c2, d2, cpcy2, cpsy2, crsy2, crcy2, srcp2, crcp2;
  trig_t srsy2, srcy2, sp2;
  always_ff @(posedge clk) begin
    a2    <= qmul(sr1, spcy);
    b2    <= qmul(sr1, spsy);
    c2    <= qmul(cr1, spcy);
    d2    <= qmul(cr1, spsy);
    cpcy2 <= cpcy;
    cpsy2 <= cpsy;
    crsy2 <= crsy;
    crcy2 <= crcy;
    srcp2 <= srcp;
    crcp2 <= crcp;
    srsy2 <= srsy;
    srcy2 <= srcy;
    sp2   <= sp1;
  end

  logic signed [SUM_W-1:0] v [9];
  always_ff @(posedge clk) begin
    v[0] <= SUM_W'(cpcy2);
    v[1] <= SUM_W'(cpsy2);
    v[2] <= -SUM_W'(sp2);
    v[3] <= SUM_W'(crsy2) - SUM_W'(a2);
    v[4] <= -SUM_W'(b2) - SUM_W'(crcy2);
    v[5] <= -SUM_W'(srcp2);
    v[6] <= SUM_W'(c2) + SUM_W'(srsy2);
    v[7] <= SUM_W'(d2) - SUM_W'(srcy2);
    v[8] <= SUM_W'(crcp2);
  end

  result_t res;
  always_ff @(posedge clk) begin
    res.forward_x <= to_out(v[0]);
    res.forward_y <= to_out(v[1]);
    res.forward_z <= to_out(v[2]);
    res.right_x   <= to_out(v[3]);
    res.right_y   <= to_out(v[4]);
    res.right_z   <= to_out(v[5]);
    res.up_x      <= to_out(v[6]);
    res.up_y      <= to_out(v[7]);
    res.up_z      <= to_out(v[8]);
  end

  // result queue: memory plus head register
  result_t         mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wptr;
  logic [OUT_AW-1:0] rptr;
  logic [OUT_AW:0]   mcount;
  logic              head_valid;
  logic              wr;
  logic              load;

  assign wr    = vpipe[PIPE-1];
  assign load  = (mcount != '0) & (~head_valid | pop_acc);
  assign empty = ~head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      mcount     <= '0;
      head_valid <= 1'b0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (load) rptr <= rptr + 1'b1;
      mcount     <= mcount + (OUT_AW+1)'(wr) - (OUT_AW+1)'(load);
      head_valid <= load | (head_valid & ~pop_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= res;
    if (load) result <= mem[rptr];
  end

endmodule

// File: src/euler_angles_to_basis_vectors.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Pitch, yaw and roll binary angles in; forward, right and up vectors out.
// ----------------------------------------------------------------------------
// Input side is a queue: drive item and raise push; the beat is taken on a
// clock edge with push high and full low. Result side is a queue as well:
// while empty is low the oldest result sits on result, and it is taken on a
// clock edge with pop high.
// Each angle is 16 bits for a full turn; each output is signed Q1.14,
// saturated to plus or minus one.
// Results pass through the CORDIC pipelines, then the product, sum and
// rounding stages and the result memory before empty goes low.
// Throughput is one beat per cycle, sustained while the receiver pops.
// A 64-entry result memory absorbs the pipeline; when the receiver stalls,
// the back end stops issuing once 64 results are outstanding, the 4-entry
// middle queue fills, then full rises.
// Synchronous reset empties every queue: empty goes high and full low.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors import eab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic cls_valid;
  cls_t cls;
  logic q_full;
  logic q_rd;
  logic q_valid;
  cls_t q_data;

  eab_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .cls_valid(cls_valid), .cls(cls), .q_full(q_full)
  );

  eab_queue u_queue (
    .clk(clk), .rst(rst), .wr(cls_valid), .wdata(cls), .q_full(q_full),
    .rd(q_rd), .q_valid(q_valid), .rdata(q_data)
  );

  eab_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_rd(q_rd),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule

// File: src/eab_checker.sv
// ----------------------------------------------------------------------------
// eab_checker
// Port-level checks for the basis-vector block, bound to the top level.
// ----------------------------------------------------------------------------
module eab_checker import eab_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // reset empties both sides
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result is never dropped
  a_keep: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result lost while stalled");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(result))
    else $error("result changed while stalled");

  // nothing comes out as soon as reset is released
  a_first: assert property (@(posedge clk) $past(rst) && !rst |-> empty)
    else $error("result before any beat");

endmodule

bind euler_angles_to_basis_vectors eab_checker u_eab_checker (.*);
